// ===== rtl/pwt_pkg.sv =====
// ----------------------------------------------------------------------------
// pwt_pkg: shared types and constants
// Pixel and window types, register indexes and reset values for the
// Prewitt edge threshold unit.
// ----------------------------------------------------------------------------
package pwt_pkg;

  typedef logic [7:0]        pixel_t;
  // window[row][col]: row 0 is the oldest line, col 2 the newest pixel
  typedef pixel_t [2:0][2:0] window_t;

  localparam int THR_W      = 7;
  localparam int THRSQ_W    = 14;
  localparam int DIM_W      = 11;
  localparam int POS_W      = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int MIN_DIM    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic [THR_W-1:0]   THRESHOLD_RST    = 7'd100;
  localparam logic [THRSQ_W-1:0] THRESHOLD_SQ_RST = 14'd10000;
  localparam logic [DIM_W-1:0]   IMAGE_WIDTH_RST  = 11'd640;
  localparam logic [DIM_W-1:0]   IMAGE_HEIGHT_RST = 11'd480;

  localparam pixel_t PIX_EDGE = 8'd0;
  localparam pixel_t PIX_FLAT = 8'd255;

endpackage

// ===== rtl/pwt_pix_if.sv =====
// ----------------------------------------------------------------------------
// pwt_pix_if: pixel request channel
// Valid/ready channel carrying one grey pixel per request.
// ----------------------------------------------------------------------------
interface pwt_pix_if import pwt_pkg::*; ();
  logic   valid;
  logic   ready;
  pixel_t pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

// ===== rtl/pwt_res_if.sv =====
// ----------------------------------------------------------------------------
// pwt_res_if: result request channel
// Valid/ready channel carrying one decided interior pixel per request.
// ----------------------------------------------------------------------------
interface pwt_res_if import pwt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] out_row;
  logic [POS_W-1:0] out_col;
  pixel_t           edge_value;
  logic             frame_last;

  modport source (output valid, output out_row, output out_col, output edge_value,
                  output frame_last, input ready);
  modport sink   (input valid, input out_row, input out_col, input edge_value,
                  input frame_last, output ready);
endinterface

// ===== rtl/pwt_cfg_if.sv =====
// ----------------------------------------------------------------------------
// pwt_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface pwt_cfg_if import pwt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/pwt_line_buf.sv =====
// ----------------------------------------------------------------------------
// pwt_line_buf: two line stores
// Upper and middle line memories, one registered read and one write a cycle.
// ----------------------------------------------------------------------------
module pwt_line_buf import pwt_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output pixel_t        upper_rd,
  output pixel_t        middle_rd,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  pixel_t        upper_wd,
  input  pixel_t        middle_wd
);

  pixel_t upper_mem  [DEPTH];
  pixel_t middle_mem [DEPTH];
  pixel_t upper_rd_r;
  pixel_t middle_rd_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      upper_rd_r  <= upper_mem[rd_addr];
      middle_rd_r <= middle_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= upper_wd;
      middle_mem[wr_addr] <= middle_wd;
    end
  end

  assign upper_rd  = upper_rd_r;
  assign middle_rd = middle_rd_r;

endmodule

// ===== rtl/pwt_grad_core.sv =====
// ----------------------------------------------------------------------------
// pwt_grad_core: Prewitt gradient and threshold decision
// Row and column sums, divide by 8 toward zero, sum of squares, compare.
// ----------------------------------------------------------------------------
module pwt_grad_core import pwt_pkg::*; (
  input  window_t              win,
  input  logic [THRSQ_W-1:0]   thr_sq,
  output pixel_t               edge_value
);

  logic [9:0]         row0, row2, col0, col2;
  logic signed [10:0] gx, gy;
  logic signed [10:0] gx_sh, gy_sh;
  logic signed [15:0] qx, qy;
  logic signed [15:0] px2, py2;
  logic [14:0]        mag;

  always_comb begin
    row0 = 10'(win[0][0]) + 10'(win[0][1]) + 10'(win[0][2]);
    row2 = 10'(win[2][0]) + 10'(win[2][1]) + 10'(win[2][2]);
    col0 = 10'(win[0][0]) + 10'(win[1][0]) + 10'(win[2][0]);
    col2 = 10'(win[0][2]) + 10'(win[1][2]) + 10'(win[2][2]);
    gx   = signed'({1'b0, row2}) - signed'({1'b0, row0});
    gy   = signed'({1'b0, col2}) - signed'({1'b0, col0});
    // bias negatives by 7 so the shift truncates toward zero
    gx_sh = (gx + (gx[10] ? 11'sd7 : 11'sd0)) >>> 3;
    gy_sh = (gy + (gy[10] ? 11'sd7 : 11'sd0)) >>> 3;
    qx    = 16'(gx_sh);
    qy    = 16'(gy_sh);
    px2   = qx * qx;
    py2   = qy * qy;
    mag   = 15'(px2) + 15'(py2);
    edge_value = (mag > 15'(thr_sq)) ? PIX_EDGE : PIX_FLAT;
  end

endmodule

// ===== rtl/prewitt_edge_threshold_unit.sv =====
// ----------------------------------------------------------------------------
// prewitt_edge_threshold_unit: streaming 3x3 Prewitt edge threshold
// Raster pixels in, one thresholded decision per interior pixel out.
// ----------------------------------------------------------------------------
// Usage:
//   in_pix  : one 8-bit grey pixel per request, raster order.
//   out_res : one request per interior pixel (row/col 1..size-2): position,
//             edge_value (0 = edge, 255 = flat) and frame_last on the final one.
//   cfg_wr  : register writes (0 threshold, 1 width, 2 height), always ready;
//             write only while the pipe is empty.
// Throughput: one pixel per clock while out_res is not stalled. Path: a result
//   shows on out_res once the pixel that completes its window has passed the
//   line store read stage, window stage and result register.
// Stall: when out_res is full and not taken, the whole pipe holds and
//   in_pix.ready drops; an empty or draining result register keeps it open.
// Border pixels produce no request. Frames follow back to back; the line
//   stores and window are not cleared between frames.
// Reset: synchronous, active low; clears counters, window, valids and loads
//   register defaults (100, 640, 480). Line stores are not cleared.
// ----------------------------------------------------------------------------
module prewitt_edge_threshold_unit import pwt_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic   clk,
  input  logic   rst_n,
  pwt_pix_if.sink   in_pix,
  pwt_res_if.source out_res,
  pwt_cfg_if.sink   cfg_wr
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  // configuration
  logic [THR_W-1:0]   thr_r;
  logic [THRSQ_W-1:0] thr_sq_r;
  logic [DIM_W-1:0]   img_w_r;
  logic [DIM_W-1:0]   img_h_r;
  logic               cfg_acc;

  // position of the next pixel
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] w_last;
  logic [RW-1:0] h_last;

  // pipe control
  logic en;
  logic acc;

  // stage 1: line store read in flight
  logic             s1_valid_r;
  pixel_t           s1_pix_r;
  logic [CW-1:0]    s1_addr_r;
  logic             s1_emit_r;
  logic             s1_last_r;
  logic [POS_W-1:0] s1_row_r;
  logic [POS_W-1:0] s1_col_r;

  // stage 2: window holds the neighborhood
  logic             s2_valid_r;
  window_t          window_r;
  logic             s2_emit_r;
  logic             s2_last_r;
  logic [POS_W-1:0] s2_row_r;
  logic [POS_W-1:0] s2_col_r;

  // result register
  logic             out_valid_r;
  logic [POS_W-1:0] out_row_r;
  logic [POS_W-1:0] out_col_r;
  pixel_t           out_edge_r;
  logic             out_last_r;

  pixel_t upper_rd, middle_rd;
  pixel_t edge_dec;
  logic   wr_en;

  // -------------------------------------------------------------------------
  // configuration registers; threshold squared is kept alongside
  // -------------------------------------------------------------------------
  assign cfg_wr.ready = 1'b1;
  assign cfg_acc      = cfg_wr.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= THRESHOLD_RST;
      thr_sq_r <= THRESHOLD_SQ_RST;
      img_w_r  <= IMAGE_WIDTH_RST;
      img_h_r  <= IMAGE_HEIGHT_RST;
    end else if (cfg_acc) begin
      case (cfg_wr.index)
        REG_THRESHOLD: begin
          thr_r    <= cfg_wr.data[THR_W-1:0];
          thr_sq_r <= THRSQ_W'(cfg_wr.data[THR_W-1:0]) *
                      THRSQ_W'(cfg_wr.data[THR_W-1:0]);
        end
        REG_IMAGE_WIDTH:  img_w_r <= cfg_wr.data;
        REG_IMAGE_HEIGHT: img_h_r <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  // clamped last column / last row
  always_comb begin
    if (32'(img_w_r) < MIN_DIM) begin
      w_last = CW'(MIN_DIM - 1);
    end else if (32'(img_w_r) > MAX_WIDTH) begin
      w_last = CW'(MAX_WIDTH - 1);
    end else begin
      w_last = CW'(img_w_r - 1'b1);
    end
    if (32'(img_h_r) < MIN_DIM) begin
      h_last = RW'(MIN_DIM - 1);
    end else if (32'(img_h_r) > MAX_HEIGHT) begin
      h_last = RW'(MAX_HEIGHT - 1);
    end else begin
      h_last = RW'(img_h_r - 1'b1);
    end
  end

  // -------------------------------------------------------------------------
  // accept stage: whole pipe moves when the result register can take data
  // -------------------------------------------------------------------------
  assign en           = !out_valid_r || out_res.ready;
  assign in_pix.ready = en;
  assign acc          = in_pix.valid && en;

  always_comb begin
    // a counter at or past its end wraps, so a geometry change still recovers
    if (col_r >= w_last) begin
      col_nxt = '0;
      row_nxt = (row_r >= h_last) ? '0 : row_r + 1'b1;
    end else begin
      col_nxt = col_r + 1'b1;
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pix_r  <= in_pix.pixel;
      s1_addr_r <= col_r;
      s1_emit_r <= (row_r >= RW'(2)) && (col_r >= CW'(2));
      s1_last_r <= (row_r == h_last) && (col_r == w_last);
      s1_row_r  <= POS_W'(row_r - 1'b1);
      s1_col_r  <= POS_W'(col_r - 1'b1);
    end
  end

  // line stores: read at accept, write back as the item enters the window
  assign wr_en = en && s1_valid_r;

  pwt_line_buf #(
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk       (clk),
    .rd_en     (acc),
    .rd_addr   (col_r),
    .upper_rd  (upper_rd),
    .middle_rd (middle_rd),
    .wr_en     (wr_en),
    .wr_addr   (s1_addr_r),
    .upper_wd  (middle_rd),
    .middle_wd (s1_pix_r)
  );

  // -------------------------------------------------------------------------
  // window stage
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      window_r   <= '0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        for (int k = 0; k < 3; k++) begin
          window_r[k][0] <= window_r[k][1];
          window_r[k][1] <= window_r[k][2];
        end
        window_r[0][2] <= upper_rd;
        window_r[1][2] <= middle_rd;
        window_r[2][2] <= s1_pix_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_valid_r) begin
      s2_emit_r <= s1_emit_r;
      s2_last_r <= s1_last_r;
      s2_row_r  <= s1_row_r;
      s2_col_r  <= s1_col_r;
    end
  end

  pwt_grad_core u_grad_core (
    .win        (window_r),
    .thr_sq     (thr_sq_r),
    .edge_value (edge_dec)
  );

  // -------------------------------------------------------------------------
  // result register
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s2_valid_r && s2_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s2_valid_r && s2_emit_r) begin
      out_row_r  <= s2_row_r;
      out_col_r  <= s2_col_r;
      out_edge_r <= edge_dec;
      out_last_r <= s2_last_r;
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.out_row    = out_row_r;
  assign out_res.out_col    = out_col_r;
  assign out_res.edge_value = out_edge_r;
  assign out_res.frame_last = out_last_r;

  // -------------------------------------------------------------------------
  // assertions
  // -------------------------------------------------------------------------
  // a new result only comes from an emitting window stage
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s2_valid_r && s2_emit_r))
    else $error("result appeared without an emitting window item");

  // a stalled pipe keeps its window
  assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(window_r))
    else $error("window changed during stall");

  // write-back never hits the address read in the same cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && acc) |-> (s1_addr_r != col_r))
    else $error("line store read/write collision");

  // the threshold square tracks the threshold
  assert property (@(posedge clk) disable iff (!rst_n)
    thr_sq_r == THRSQ_W'(thr_r) * THRSQ_W'(thr_r))
    else $error("threshold square out of step");

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the Prewitt edge threshold unit
// Streams raster frames into the unit, mirrors the line stores, window and
// counters in a local predictor, and checks every decided interior pixel
// (position, edge value, last flag) in order against the prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import pwt_pkg::*;

  localparam int MAX_W         = 1024;
  localparam int MAX_H         = 1024;
  localparam int RANDOM_ITEMS  = 1100;
  // results trail the completing pixel through the pipe registers; leave some margin
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 200000;
  // keep a wide margin over the slowest run
  localparam int CYCLE_LIMIT   = 3000000;
  localparam int REPORT_CAP    = 200;

  // index 3 has no register behind it; writes must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    pixel_t           edge_value;
    logic             frame_last;
  } decision_t;

  typedef enum int {
    STYLE_NOISE,
    STYLE_EXTREMES,
    STYLE_RAMP,
    STYLE_BLOCKS,
    STYLE_TOP_BRIGHT,
    STYLE_RIGHT_BRIGHT
  } frame_style_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  pwt_pix_if in_pix ();
  pwt_res_if out_res ();
  pwt_cfg_if cfg_wr ();

  prewitt_edge_threshold_unit #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (in_pix),
    .out_res (out_res),
    .cfg_wr  (cfg_wr)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Stimulus and scoreboard storage
  // --------------------------------------------------------------------------
  pixel_t    pixel_feed [$];        // pixels waiting to be offered
  decision_t pending_decisions [$]; // predicted decisions, oldest first
  logic      pixel_presenting = 1'b0;

  int source_idle_pct = 0;
  int sink_stall_pct  = 0;
  int mismatches      = 0;
  int pixels_sent     = 0;
  int decisions_seen  = 0;
  int frames_queued   = 0;
  int phases_run      = 0;
  int cycle_count     = 0;

  // --------------------------------------------------------------------------
  // Predictor state: mirror of the unit's registers, stores and counters
  // --------------------------------------------------------------------------
  pixel_t           line_up  [MAX_W];
  pixel_t           line_mid [MAX_W];
  window_t          win      = '0;
  int               row_pos  = 0;
  int               col_pos  = 0;
  logic [THR_W-1:0] thr_q    = THRESHOLD_RST;
  logic [DIM_W-1:0] width_q  = IMAGE_WIDTH_RST;
  logic [DIM_W-1:0] height_q = IMAGE_HEIGHT_RST;

  // out-of-range geometry is clamped when used, not when written
  function automatic int clamp_dim(input int v, input int maxv);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // One accepted pixel: shift the window, rotate the line stores, decide the
  // pixel one up and one left when the window is fully interior, advance.
  task automatic predict_decision(input pixel_t px);
    int        w;
    int        h;
    int        r;
    int        c;
    int        idx;
    int        gx;
    int        gy;
    int        mag;
    int        thr;
    decision_t d;
    w   = clamp_dim(int'(width_q), MAX_W);
    h   = clamp_dim(int'(height_q), MAX_H);
    r   = row_pos;
    c   = col_pos;
    idx = c % MAX_W;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2]     = line_up[idx];
    win[1][2]     = line_mid[idx];
    win[2][2]     = px;
    line_up[idx]  = line_mid[idx];
    line_mid[idx] = px;

    if (r >= 2 && c >= 2) begin
      gx = 0;
      gy = 0;
      for (int k = 0; k < 3; k++) begin
        gx += int'(win[2][k]) - int'(win[0][k]);  // row below minus row above
        gy += int'(win[k][2]) - int'(win[k][0]);  // right column minus left
      end
      // integer divide truncates toward zero, as the unit does
      gx  = gx / 8;
      gy  = gy / 8;
      mag = gx * gx + gy * gy;
      thr = int'(thr_q);
      d.row        = POS_W'(r - 1);
      d.col        = POS_W'(c - 1);
      d.edge_value = (mag > thr * thr) ? PIX_EDGE : PIX_FLAT;
      d.frame_last = (r == h - 1 && c == w - 1);
      pending_decisions.push_back(d);
    end

    // counters at or past their last position wrap on the next advance
    if (c >= w - 1) begin
      col_pos = 0;
      row_pos = (r >= h - 1) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  // Pixels still needed to bring the counters back to the frame start.
  function automatic int pixels_to_frame_end();
    int w;
    int h;
    int r;
    int c;
    int n;
    w = clamp_dim(int'(width_q), MAX_W);
    h = clamp_dim(int'(height_q), MAX_H);
    r = row_pos;
    c = col_pos;
    n = 0;
    do begin
      n++;
      if (c >= w - 1) begin
        c = 0;
        r = (r >= h - 1) ? 0 : r + 1;
      end else begin
        c++;
      end
    end while (r != 0 || c != 0);
    return n;
  endfunction

  task automatic report_field(input string name, input int want, input int got);
    mismatches++;
    if (mismatches <= REPORT_CAP) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_decision();
    decision_t want;
    if (pending_decisions.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_CAP) begin
        $display("%0t: unexpected result, expected none, actual row %0d col %0d",
                 $time, out_res.out_row, out_res.out_col);
      end
    end else begin
      want = pending_decisions.pop_front();
      if (out_res.out_row !== want.row)
        report_field("out_row", int'(want.row), int'(out_res.out_row));
      if (out_res.out_col !== want.col)
        report_field("out_col", int'(want.col), int'(out_res.out_col));
      if (out_res.edge_value !== want.edge_value)
        report_field("edge_value", int'(want.edge_value), int'(out_res.edge_value));
      if (out_res.frame_last !== want.frame_last)
        report_field("frame_last", int'(want.frame_last), int'(out_res.frame_last));
    end
    decisions_seen++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: falling edge. Offers the head of the pixel feed and holds it until
  // taken; result ready toggles at the sink stall rate.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    out_res.ready <= ($urandom_range(99) >= sink_stall_pct);
    if (!pixel_presenting) begin
      if (rst_n && pixel_feed.size() != 0 && $urandom_range(99) >= source_idle_pct) begin
        in_pix.valid     <= 1'b1;
        in_pix.pixel     <= pixel_feed[0];
        pixel_presenting = 1'b1;
      end else begin
        in_pix.valid <= 1'b0;
        in_pix.pixel <= pixel_t'($urandom_range(255));  // junk while idle
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: rising edge. Results are checked before the newly taken pixel is
  // predicted; a pixel's own decision cannot show at the edge it is taken.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_res.valid && out_res.ready) begin
        check_decision();
      end
      if (in_pix.valid && in_pix.ready) begin
        predict_decision(in_pix.pixel);
        void'(pixel_feed.pop_front());
        pixel_presenting = 1'b0;
        pixels_sent++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Register write on the config channel; the local mirror follows the same
  // masking as the unit. Only called while the pipe is empty.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= index;
    cfg_wr.data  <= data;
    do @(posedge clk); while (!cfg_wr.ready);
    case (index)
      REG_THRESHOLD:    thr_q    = data[THR_W-1:0];
      REG_IMAGE_WIDTH:  width_q  = data;
      REG_IMAGE_HEIGHT: height_q = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_wr.valid <= 1'b0;
    cfg_wr.data  <= CFG_DATA_W'($urandom_range(2047));
  endtask

  // Queue count pixels laid out on lines of width w, content by style.
  task automatic queue_pixels(input int w, input int count, input frame_style_t style);
    int r;
    int c;
    int a;
    int b;
    int v;
    a = $urandom_range(255);
    b = $urandom_range(255);
    for (int i = 0; i < count; i++) begin
      r = i / w;
      c = i % w;
      case (style)
        STYLE_EXTREMES:     v = $urandom_range(1) ? 255 : 0;
        STYLE_RAMP:         v = (r * (a % 24) + c * (b % 24) + $urandom_range(15)) % 256;
        STYLE_BLOCKS:       v = (((r / 2) + (c / 2)) % 2) ? a : b;
        STYLE_TOP_BRIGHT:   v = (r == 0) ? 255 : 0;
        STYLE_RIGHT_BRIGHT: v = (c == w - 1) ? 255 : 0;
        default:            v = $urandom_range(255);
      endcase
      pixel_feed.push_back(pixel_t'(v));
    end
  endtask

  // Everything offered, taken and decided, then a few cycles for border
  // pixels that are still in the pipe without a decision behind them.
  task automatic wait_idle();
    do @(posedge clk);
    while (pixel_feed.size() != 0 || pixel_presenting || pending_decisions.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      1:       begin source_idle_pct = 66; sink_stall_pct = 0;  end
      2:       begin source_idle_pct = 0;  sink_stall_pct = 66; end
      3:       begin source_idle_pct = 25; sink_stall_pct = 25; end
      default: begin source_idle_pct = 0;  sink_stall_pct = 0;  end
    endcase
  endtask

  // threshold data: extremes often, above 125 included, random upper data bits
  function automatic logic [CFG_DATA_W-1:0] pick_threshold();
    int t;
    case ($urandom_range(4))
      0:       t = $urandom_range(1) ? $urandom_range(125, 127) : 0;
      default: t = $urandom_range(127);
    endcase
    return {4'($urandom_range(15)), 7'(t)};
  endfunction

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles", $time, cycle_count);
    $display("FAIL prewitt_edge_threshold_unit");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int random_pixels;
    int phase;
    int w_val;
    int h_val;
    int n_frames;
    int waited;
    int n_left;

    random_pixels = 0;
    phase         = 0;
    for (int i = 0; i < MAX_W; i++) begin
      line_up[i]  = '0;
      line_mid[i] = '0;
    end

    in_pix.valid  = 1'b0;
    in_pix.pixel  = '0;
    out_res.ready = 1'b0;
    cfg_wr.valid  = 1'b0;
    cfg_wr.index  = '0;
    cfg_wr.data   = '0;

    // single reset at start
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // ---- directed, no idling -----------------------------------------------
    set_idling(0);
    // 3x3 frame with the default threshold: bright top row, gx = -765/8
    cfg_write(REG_IMAGE_WIDTH, 11'd3);
    cfg_write(REG_IMAGE_HEIGHT, 11'd3);
    queue_pixels(3, 9, STYLE_TOP_BRIGHT);
    frames_queued++;
    wait_idle();

    // threshold 95 with upper data bits set: truncation toward zero keeps
    // the square at 9025, not above 95^2, so the pixel stays flat
    cfg_write(REG_THRESHOLD, 11'h780 | 11'd95);
    cfg_write(REG_UNUSED, 11'h7ff);
    queue_pixels(3, 9, STYLE_TOP_BRIGHT);
    frames_queued++;
    wait_idle();

    // threshold 0: any gradient is an edge; bright right column gives gy
    cfg_write(REG_THRESHOLD, 11'd0);
    queue_pixels(3, 9, STYLE_RIGHT_BRIGHT);
    frames_queued++;
    wait_idle();
    phases_run++;

    // ---- geometry change mid-frame -----------------------------------------
    // a full 8x6 frame first, so every column below 8 is written in both
    // line stores before the width shrinks
    cfg_write(REG_THRESHOLD, pick_threshold());
    cfg_write(REG_IMAGE_WIDTH, 11'd8);
    cfg_write(REG_IMAGE_HEIGHT, 11'd6);
    queue_pixels(8, 48, STYLE_NOISE);
    queue_pixels(8, 21, STYLE_NOISE);  // stop at row 2, column 5
    frames_queued++;
    wait_idle();
    // column 5 is past the new last column: it wraps on the next pixel
    cfg_write(REG_IMAGE_WIDTH, 11'd4);
    cfg_write(REG_IMAGE_HEIGHT, 11'd4);
    n_left = pixels_to_frame_end();
    queue_pixels(4, n_left, STYLE_NOISE);
    frames_queued++;
    wait_idle();
    // row counter past the new last row: wraps at the end of the line
    cfg_write(REG_IMAGE_HEIGHT, 11'd6);
    queue_pixels(4, 18, STYLE_EXTREMES);  // stop at row 4, column 2
    wait_idle();
    cfg_write(REG_IMAGE_HEIGHT, 11'd4);
    n_left = pixels_to_frame_end();
    queue_pixels(4, n_left, STYLE_NOISE);
    frames_queued++;
    wait_idle();
    phases_run++;

    // ---- random phases -----------------------------------------------------
    // small frames, back to back; idling mode rotates per phase
    while (random_pixels < RANDOM_ITEMS) begin
      set_idling(phase % 4);
      if ($urandom_range(3) != 0) cfg_write(REG_THRESHOLD, pick_threshold());
      if ($urandom_range(2) != 0) begin
        // low values 0..2 exercise the clamp up to three
        w_val = ($urandom_range(6) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
        h_val = ($urandom_range(6) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
        if ($urandom_range(1)) begin
          cfg_write(REG_IMAGE_WIDTH, DIM_W'(w_val));
          cfg_write(REG_IMAGE_HEIGHT, DIM_W'(h_val));
        end else begin
          cfg_write(REG_IMAGE_HEIGHT, DIM_W'(h_val));
          cfg_write(REG_IMAGE_WIDTH, DIM_W'(w_val));
        end
      end
      w_val    = clamp_dim(int'(width_q), MAX_W);
      h_val    = clamp_dim(int'(height_q), MAX_H);
      n_frames = $urandom_range(1, 3);
      for (int f = 0; f < n_frames; f++) begin
        queue_pixels(w_val, w_val * h_val, frame_style_t'($urandom_range(3)));
        frames_queued++;
        random_pixels += w_val * h_val;
      end
      wait_idle();
      phase++;
      phases_run++;
    end

    // ---- drain -------------------------------------------------------------
    while (pixel_feed.size() != 0 || pixel_presenting) @(posedge clk);
    waited = 0;
    while (pending_decisions.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_decisions.size() != 0) begin
      mismatches += pending_decisions.size();
      $display("%0t: %0d expected results never arrived", $time, pending_decisions.size());
    end

    $display("Streamed %0d pixels in %0d frames over %0d phases, %0d decisions checked.",
             pixels_sent, frames_queued, phases_run, decisions_seen);
    $display("Geometry 3..12 incl. clamped and mid-frame changes, thresholds 0..127.");
    if (mismatches == 0) begin
      $display("PASS prewitt_edge_threshold_unit");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL prewitt_edge_threshold_unit");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pwt_pkg.sv
rtl/pwt_pix_if.sv
rtl/pwt_res_if.sv
rtl/pwt_cfg_if.sv
rtl/pwt_line_buf.sv
rtl/pwt_grad_core.sv
rtl/prewitt_edge_threshold_unit.sv
tb/sv/tb_top.sv
